[hdl/pcg_pkg.sv]
`default_nettype none
package pcg_pkg;

  // Field and register widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned StateW  = 64;
  localparam int unsigned StreamW = 63;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 64;

  // LCG multiplier and the state after seeding from seed 0, stream 0
  localparam logic [StateW-1:0] LcgMult    = 64'd6364136223846793005;
  localparam logic [StateW-1:0] ResetState = 64'd6364136223846793006;
  localparam logic [StateW-1:0] ResetInc   = 64'd1;

  // Output permutation shifts
  localparam int unsigned XshShift   = 18;
  localparam int unsigned XshDrop    = 27;
  localparam int unsigned RotShift   = 59;

  // Commands
  typedef enum logic [CmdW-1:0] {
    CMD_RAW     = 2'd0,
    CMD_RANGE_U = 2'd1,
    CMD_RANGE_S = 2'd2,
    CMD_RESEED  = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_SEED   = 1'b0,
    REG_STREAM = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RAW,
    ST_SEED1,
    ST_SEED2,
    ST_LIMIT,
    ST_DRAW,
    ST_TEST,
    ST_REDUCE,
    ST_FINISH
  } fsm_t;

  // Request to the LCG step unit
  typedef struct packed {
    logic              start;
    logic [StateW-1:0] state;
    logic [StateW-1:0] inc;
  } step_req_t;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

[hdl/pcg_cfg_regs.sv]
`default_nettype none
module pcg_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pcg_pkg::CfgAddrW-1:0]      paddr,
  input  wire logic [pcg_pkg::CfgDataW-1:0]      pwdata,
  output logic      [pcg_pkg::CfgDataW-1:0]      prdata,
  output logic                                   pready,
  output logic      [pcg_pkg::StateW-1:0]        seed_value,
  output logic      [pcg_pkg::StreamW-1:0]       stream_select
);

  logic [pcg_pkg::StateW-1:0]  seed_r;
  logic [pcg_pkg::StreamW-1:0] stream_r;
  logic                        wr_en;
  pcg_pkg::reg_idx_t           idx;

  // Registers sit at 8-byte spacing
  assign idx    = pcg_pkg::reg_idx_t'(paddr[3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      stream_r <= '0;
    end else if (wr_en) begin
      case (idx)
        pcg_pkg::REG_SEED:   seed_r   <= pwdata;
        pcg_pkg::REG_STREAM: stream_r <= pwdata[pcg_pkg::StreamW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      pcg_pkg::REG_SEED:   prdata = seed_r;
      pcg_pkg::REG_STREAM: prdata = {1'b0, stream_r};
      default:             prdata = '0;
    endcase
  end

  assign seed_value    = seed_r;
  assign stream_select = stream_r;

endmodule
`default_nettype wire

[hdl/pcg_lcg_step.sv]
`default_nettype none
// One LCG step, state * mult + inc mod 2^64, on one shared 32x32 multiplier
// over three passes: lo*lo, lo*hi (low half), hi*lo (low half) plus inc.
module pcg_lcg_step (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pcg_pkg::step_req_t         req,
  output logic                            done,
  output logic [pcg_pkg::StateW-1:0]      result
);

  localparam int unsigned W = pcg_pkg::WordW;

  logic [pcg_pkg::StateW-1:0] a_r;
  logic [pcg_pkg::StateW-1:0] inc_r;
  logic [pcg_pkg::StateW-1:0] acc_r, acc_nxt;
  logic [1:0]                 phase_r;
  logic                       busy_r;
  logic                       done_r;
  logic [W-1:0]               op_a, op_b;
  logic [2*W-1:0]             prod;

  // Operand select per pass
  always_comb begin
    case (phase_r)
      2'd0:    begin op_a = a_r[W-1:0]; op_b = pcg_pkg::LcgMult[W-1:0]; end
      2'd1:    begin op_a = a_r[W-1:0]; op_b = pcg_pkg::LcgMult[2*W-1:W]; end
      default: begin op_a = a_r[2*W-1:W]; op_b = pcg_pkg::LcgMult[W-1:0]; end
    endcase
  end

  assign prod = (2*W)'(op_a) * (2*W)'(op_b);

  // Accumulate partial products
  always_comb begin
    case (phase_r)
      2'd0:    acc_nxt = prod;
      2'd1:    acc_nxt = acc_r + {prod[W-1:0], {W{1'b0}}};
      default: acc_nxt = acc_r + {prod[W-1:0], {W{1'b0}}} + inc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      done_r <= busy_r && (phase_r == 2'd2);
      if (req.start) begin
        busy_r  <= 1'b1;
        phase_r <= '0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd2) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.state;
      inc_r <= req.inc;
    end
    if (busy_r) acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire

[hdl/pcg_rem_unit.sv]
`default_nettype none
// Restoring 32-bit remainder, one quotient bit per cycle.
module pcg_rem_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pcg_pkg::div_req_t       req,
  output logic                         done,
  output logic [pcg_pkg::WordW-1:0]    remainder
);

  localparam int unsigned W  = pcg_pkg::WordW;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  // Shift in next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_r, dvd_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    rem_nxt = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(W-1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W-1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[hdl/pcg32_random_generator.sv]
`default_nettype none
// PCG32 (XSH-RR) generator with raw, unsigned-range, signed-range and reseed
// commands; each accepted command yields one result beat. The 64-bit LCG step
// runs on one 32x32 multiplier over three passes, and ranged draws use a
// bit-serial remainder unit twice per ranged command; each rejected draw costs
// another LCG step. An empty range returns range_error with value 0 and
// leaves the state untouched. The input side is busy while a command is in
// progress; a finished result waits until the output register is free, and
// in_ready rises together with out_valid as the result moves into that
// register. seed_value lives at byte address 0 and stream_select at 8;
// write them only while the block is idle.
module pcg32_random_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [pcg_pkg::CmdW-1:0]        in_cmd,
  input  wire logic [pcg_pkg::WordW-1:0]       in_range_low,
  input  wire logic [pcg_pkg::WordW-1:0]       in_range_high,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [pcg_pkg::WordW-1:0]       out_value,
  output logic                                 out_range_error,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [pcg_pkg::CfgAddrW-1:0]    cfg_paddr,
  input  wire logic [pcg_pkg::CfgDataW-1:0]    cfg_pwdata,
  output logic      [pcg_pkg::CfgDataW-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int unsigned W  = pcg_pkg::WordW;
  localparam int unsigned SW = pcg_pkg::StateW;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  pcg_pkg::fsm_t       fsm_r, fsm_nxt;
  pcg_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [W-1:0]        lo_r, lo_nxt;
  logic [W-1:0]        hi_r, hi_nxt;
  logic [W-1:0]        bound_r, bound_nxt;
  logic [W-1:0]        limit_r, limit_nxt;
  logic [W-1:0]        draw_r, draw_nxt;
  logic [W-1:0]        res_val_r, res_val_nxt;
  logic                res_err_r, res_err_nxt;
  logic [SW-1:0]       gen_state_r, gen_state_nxt;
  logic [SW-1:0]       inc_r, inc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [W-1:0]        out_value_r, out_value_nxt;
  logic                out_err_r, out_err_nxt;

  logic [SW-1:0]                seed_value;
  logic [pcg_pkg::StreamW-1:0]  stream_select;
  pcg_pkg::step_req_t           step_req;
  logic                         step_done;
  logic [SW-1:0]                step_result;
  pcg_pkg::div_req_t            div_req;
  logic                         div_done;
  logic [W-1:0]                 div_rem;
  logic                         accept;
  logic                         ordered;
  logic                         out_load;
  logic [W-1:0]                 xsh_out;

  // XSH-RR output permutation of a state word
  function automatic logic [W-1:0] xsh_rr(input logic [SW-1:0] s);
    logic [SW-1:0]  mix64;
    logic [W-1:0]   mixed;
    logic [4:0]     rot;
    logic [2*W-1:0] dbl;
    begin
      mix64 = ((s >> pcg_pkg::XshShift) ^ s) >> pcg_pkg::XshDrop;
      mixed = mix64[W-1:0];
      rot   = s[pcg_pkg::RotShift +: 5];
      dbl   = {mixed, mixed} >> rot;
      xsh_rr = dbl[W-1:0];
    end
  endfunction

  pcg_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .seed_value    (seed_value),
    .stream_select (stream_select)
  );

  pcg_lcg_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (step_req),
    .done   (step_done),
    .result (step_result)
  );

  pcg_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_ready = (fsm_r == pcg_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_load = !out_valid_r || out_ready;
  assign xsh_out  = xsh_rr(gen_state_r);

  // Range order check, unsigned or signed
  always_comb begin
    if (cmd_r == pcg_pkg::CMD_RANGE_S) ordered = (lo_r ^ SignBit) < (hi_r ^ SignBit);
    else                               ordered = lo_r < hi_r;
  end

  // Next state
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      pcg_pkg::ST_IDLE:   if (accept) fsm_nxt = pcg_pkg::ST_DECODE;
      pcg_pkg::ST_DECODE: begin
        case (cmd_r)
          pcg_pkg::CMD_RAW:    fsm_nxt = pcg_pkg::ST_RAW;
          pcg_pkg::CMD_RESEED: fsm_nxt = pcg_pkg::ST_SEED1;
          default:             fsm_nxt = ordered ? pcg_pkg::ST_LIMIT : pcg_pkg::ST_FINISH;
        endcase
      end
      pcg_pkg::ST_RAW:    if (step_done) fsm_nxt = pcg_pkg::ST_FINISH;
      pcg_pkg::ST_SEED1:  if (step_done) fsm_nxt = pcg_pkg::ST_SEED2;
      pcg_pkg::ST_SEED2:  if (step_done) fsm_nxt = pcg_pkg::ST_FINISH;
      pcg_pkg::ST_LIMIT:  if (div_done)  fsm_nxt = pcg_pkg::ST_DRAW;
      pcg_pkg::ST_DRAW:   if (step_done) fsm_nxt = pcg_pkg::ST_TEST;
      pcg_pkg::ST_TEST:   fsm_nxt = (draw_r >= limit_r) ? pcg_pkg::ST_REDUCE
                                                        : pcg_pkg::ST_DRAW;
      pcg_pkg::ST_REDUCE: if (div_done)  fsm_nxt = pcg_pkg::ST_FINISH;
      pcg_pkg::ST_FINISH: if (out_load)  fsm_nxt = pcg_pkg::ST_IDLE;
      default:            fsm_nxt = pcg_pkg::ST_IDLE;
    endcase
  end

  // Datapath and unit requests
  always_comb begin
    cmd_nxt       = cmd_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bound_nxt     = bound_r;
    limit_nxt     = limit_r;
    draw_nxt      = draw_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    gen_state_nxt = gen_state_r;
    inc_nxt       = inc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    step_req      = '{start: 1'b0, state: gen_state_r, inc: inc_r};
    div_req       = '{start: 1'b0, dividend: draw_r, divisor: bound_r};

    case (fsm_r)
      pcg_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = pcg_pkg::cmd_t'(in_cmd);
          lo_nxt  = in_range_low;
          hi_nxt  = in_range_high;
        end
      end
      pcg_pkg::ST_DECODE: begin
        res_val_nxt = '0;
        res_err_nxt = 1'b0;
        case (cmd_r)
          pcg_pkg::CMD_RAW: step_req.start = 1'b1;
          pcg_pkg::CMD_RESEED: begin
            // First seeding step from a zero state
            inc_nxt        = {stream_select, 1'b1};
            step_req.start = 1'b1;
            step_req.state = '0;
            step_req.inc   = {stream_select, 1'b1};
          end
          default: begin
            if (ordered) begin
              // limit = (2^32 - bound) mod bound
              bound_nxt        = hi_r - lo_r;
              div_req.start    = 1'b1;
              div_req.dividend = W'(0) - (hi_r - lo_r);
              div_req.divisor  = hi_r - lo_r;
            end else begin
              res_err_nxt = 1'b1;
            end
          end
        endcase
      end
      pcg_pkg::ST_RAW: begin
        if (step_done) begin
          res_val_nxt   = xsh_out;
          gen_state_nxt = step_result;
        end
      end
      pcg_pkg::ST_SEED1: begin
        if (step_done) begin
          step_req.start = 1'b1;
          step_req.state = step_result + seed_value;
        end
      end
      pcg_pkg::ST_SEED2: begin
        if (step_done) gen_state_nxt = step_result;
      end
      pcg_pkg::ST_LIMIT: begin
        if (div_done) begin
          limit_nxt      = div_rem;
          step_req.start = 1'b1;
        end
      end
      pcg_pkg::ST_DRAW: begin
        if (step_done) begin
          draw_nxt      = xsh_out;
          gen_state_nxt = step_result;
        end
      end
      pcg_pkg::ST_TEST: begin
        // Keep the draw or reject it and step again
        if (draw_r >= limit_r) div_req.start  = 1'b1;
        else                   step_req.start = 1'b1;
      end
      pcg_pkg::ST_REDUCE: begin
        if (div_done) res_val_nxt = lo_r + div_rem;
      end
      pcg_pkg::ST_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_val_r;
          out_err_nxt   = res_err_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= pcg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      gen_state_r <= pcg_pkg::ResetState;
      inc_r       <= pcg_pkg::ResetInc;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= out_valid_nxt;
      gen_state_r <= gen_state_nxt;
      inc_r       <= inc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    bound_r     <= bound_nxt;
    limit_r     <= limit_nxt;
    draw_r      <= draw_nxt;
    res_val_r   <= res_val_nxt;
    res_err_r   <= res_err_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_range_error = out_err_r;

endmodule
`default_nettype wire
